[rtl/sxt_pkg.sv]
package sxt_pkg;

  localparam int unsigned RunDepth = 4;

  localparam logic [2:0] KIND_NONE  = 3'd0;
  localparam logic [2:0] KIND_OPEN  = 3'd0;
  localparam logic [2:0] KIND_CLOSE = 3'd1;
  localparam logic [2:0] KIND_NUM   = 3'd2;
  localparam logic [2:0] KIND_SYM   = 3'd3;
  localparam logic [2:0] KIND_STR   = 3'd4;

  localparam logic [7:0] CH_MINUS     = 8'h2D;
  localparam logic [7:0] CH_DOT       = 8'h2E;
  localparam logic [7:0] CH_LPAREN    = 8'h28;
  localparam logic [7:0] CH_RPAREN    = 8'h29;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_LOWER_N   = 8'h6E;
  localparam logic [7:0] CH_LOWER_T   = 8'h74;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_NINE      = 8'h39;
  localparam logic [7:0] CH_PRINT_LO  = 8'h21;
  localparam logic [7:0] CH_PRINT_HI  = 8'h7E;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_MINUS = 3'd1,
    MODE_INT   = 3'd2,
    MODE_FRAC  = 3'd3,
    MODE_SYM   = 3'd4,
    MODE_STR   = 3'd5,
    MODE_ESC   = 3'd6,
    MODE_HALT  = 3'd7
  } mode_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] ch;
    logic       has;
    logic       first;
    logic       last;
    logic       err;
  } item_t;

  typedef struct packed {
    item_t [RunDepth-1:0] items;
    logic  [2:0]          count;
  } run_t;

  function automatic item_t mk_item(logic [2:0] kind, logic [7:0] ch, logic has,
                                    logic first, logic last, logic err);
    item_t it;
    it.kind  = kind;
    it.ch    = ch;
    it.has   = has;
    it.first = first;
    it.last  = last;
    it.err   = err;
    return it;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_symchar(logic [7:0] c);
    return (c >= CH_PRINT_LO) && (c <= CH_PRINT_HI) && (c != CH_LPAREN) &&
           (c != CH_RPAREN) && (c != CH_QUOTE);
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NEWLINE);
  endfunction

endpackage

[rtl/sexpr_tokenizer.sv]
// Streaming S-expression lexer. Source bytes enter on the input channel, with
// end_of_source set on the last byte; tokens leave as runs of tagged items,
// token_first on the first and token_last on the final item, and run_end on
// the last item caused by one byte. A byte is decoded against the scan state
// in the cycle it is transferred and its items (up to three) are loaded into
// an output run buffer that drains one item per cycle while out_ready is high.
// A byte is taken every cycle while it gives at most one item and out_ready
// is high; a byte that gives more items holds the input, which is taken again
// in the cycle its last item is transferred. Bytes that give no item
// (whitespace, a minus, an opening quote, a backslash inside a string) load
// an empty run and leave the input ready. After a byte that cannot start a
// token the block reports an error for every later byte until reset.
module sexpr_tokenizer (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] char_in,
  input  logic       end_of_source,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] token_kind,
  output logic [7:0] token_char,
  output logic       has_char,
  output logic       token_first,
  output logic       token_last,
  output logic       error_flag,
  output logic       run_end
);
  import sxt_pkg::*;

  mode_t mode;
  mode_t mode_next;
  logic  open;
  logic  open_next;
  run_t  run;
  item_t item;
  logic  can_load;
  logic  load;

  assign in_ready = can_load;
  assign load     = in_valid && can_load;

  sxt_decode u_decode (
    .char_in       (char_in),
    .end_of_source (end_of_source),
    .mode          (mode),
    .open          (open),
    .mode_next     (mode_next),
    .open_next     (open_next),
    .run           (run)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_IDLE;
      open <= 1'b0;
    end else if (load) begin
      mode <= mode_next;
      open <= open_next;
    end
  end

  sxt_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .run       (run),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .item      (item),
    .run_end   (run_end)
  );

  assign token_kind  = item.kind;
  assign token_char  = item.ch;
  assign has_char    = item.has;
  assign token_first = item.first;
  assign token_last  = item.last;
  assign error_flag  = item.err;

endmodule

[rtl/sxt_decode.sv]
module sxt_decode (
  input  logic [7:0]    char_in,
  input  logic          end_of_source,
  input  sxt_pkg::mode_t mode,
  input  logic          open,
  output sxt_pkg::mode_t mode_next,
  output logic          open_next,
  output sxt_pkg::run_t run
);
  import sxt_pkg::*;

  item_t [RunDepth-1:0] items;
  logic  [2:0]          cnt;
  mode_t                m;
  logic                 op;
  logic                 do_start;

  always_comb begin
    items    = '0;
    cnt      = 3'd0;
    m        = mode;
    op       = open;
    do_start = 1'b0;

    unique case (mode)
      MODE_HALT: begin
        items[cnt[1:0]] = mk_item(KIND_NONE, 8'd0, 1'b0, 1'b0, 1'b0, 1'b1);
        cnt = cnt + 3'd1;
      end
      MODE_MINUS: begin
        if (is_digit(char_in)) begin
          items[cnt[1:0]] = mk_item(KIND_NUM, CH_MINUS, 1'b1, !op, 1'b0, 1'b0);
          op = 1'b1;
          cnt = cnt + 3'd1;
          items[cnt[1:0]] = mk_item(KIND_NUM, char_in, 1'b1, !op, 1'b0, 1'b0);
          cnt = cnt + 3'd1;
          m = MODE_INT;
        end else if (is_symchar(char_in)) begin
          items[cnt[1:0]] = mk_item(KIND_SYM, CH_MINUS, 1'b1, !op, 1'b0, 1'b0);
          op = 1'b1;
          cnt = cnt + 3'd1;
          items[cnt[1:0]] = mk_item(KIND_SYM, char_in, 1'b1, !op, 1'b0, 1'b0);
          cnt = cnt + 3'd1;
          m = MODE_SYM;
        end else begin
          items[cnt[1:0]] = mk_item(KIND_SYM, CH_MINUS, 1'b1, 1'b1, 1'b1, 1'b0);
          cnt = cnt + 3'd1;
          do_start = 1'b1;
        end
      end
      MODE_INT, MODE_FRAC: begin
        if (is_digit(char_in) || (mode == MODE_INT && char_in == CH_DOT)) begin
          items[cnt[1:0]] = mk_item(KIND_NUM, char_in, 1'b1, !op, 1'b0, 1'b0);
          op = 1'b1;
          cnt = cnt + 3'd1;
          if (char_in == CH_DOT) begin
            m = MODE_FRAC;
          end
        end else begin
          items[cnt[1:0]] = mk_item(KIND_NUM, 8'd0, 1'b0, !op, 1'b1, 1'b0);
          cnt = cnt + 3'd1;
          do_start = 1'b1;
        end
      end
      MODE_SYM: begin
        if (is_symchar(char_in)) begin
          items[cnt[1:0]] = mk_item(KIND_SYM, char_in, 1'b1, !op, 1'b0, 1'b0);
          op = 1'b1;
          cnt = cnt + 3'd1;
        end else begin
          items[cnt[1:0]] = mk_item(KIND_SYM, 8'd0, 1'b0, !op, 1'b1, 1'b0);
          cnt = cnt + 3'd1;
          do_start = 1'b1;
        end
      end
      MODE_STR: begin
        if (char_in == CH_BACKSLASH) begin
          m = MODE_ESC;
        end else if (char_in == CH_QUOTE) begin
          items[cnt[1:0]] = mk_item(KIND_STR, 8'd0, 1'b0, !op, 1'b1, 1'b0);
          cnt = cnt + 3'd1;
          op = 1'b0;
          m = MODE_IDLE;
        end else begin
          items[cnt[1:0]] = mk_item(KIND_STR, char_in, 1'b1, !op, 1'b0, 1'b0);
          op = 1'b1;
          cnt = cnt + 3'd1;
        end
      end
      MODE_ESC: begin
        if (char_in == CH_LOWER_N) begin
          items[cnt[1:0]] = mk_item(KIND_STR, CH_NEWLINE, 1'b1, !op, 1'b0, 1'b0);
        end else if (char_in == CH_LOWER_T) begin
          items[cnt[1:0]] = mk_item(KIND_STR, CH_TAB, 1'b1, !op, 1'b0, 1'b0);
        end else begin
          items[cnt[1:0]] = mk_item(KIND_STR, char_in, 1'b1, !op, 1'b0, 1'b0);
        end
        op = 1'b1;
        cnt = cnt + 3'd1;
        m = MODE_STR;
      end
      MODE_IDLE: begin
        do_start = 1'b1;
      end
      default: begin
        do_start = 1'b1;
      end
    endcase

    // byte begins a new token
    if (do_start) begin
      op = 1'b0;
      m = MODE_IDLE;
      if (is_space(char_in)) begin
        m = MODE_IDLE;
      end else if (char_in == CH_LPAREN) begin
        items[cnt[1:0]] = mk_item(KIND_OPEN, char_in, 1'b1, 1'b1, 1'b1, 1'b0);
        cnt = cnt + 3'd1;
      end else if (char_in == CH_RPAREN) begin
        items[cnt[1:0]] = mk_item(KIND_CLOSE, char_in, 1'b1, 1'b1, 1'b1, 1'b0);
        cnt = cnt + 3'd1;
      end else if (char_in == CH_MINUS) begin
        m = MODE_MINUS;
      end else if (is_digit(char_in)) begin
        items[cnt[1:0]] = mk_item(KIND_NUM, char_in, 1'b1, 1'b1, 1'b0, 1'b0);
        cnt = cnt + 3'd1;
        op = 1'b1;
        m = MODE_INT;
      end else if (char_in == CH_QUOTE) begin
        m = MODE_STR;
      end else if (is_symchar(char_in)) begin
        items[cnt[1:0]] = mk_item(KIND_SYM, char_in, 1'b1, 1'b1, 1'b0, 1'b0);
        cnt = cnt + 3'd1;
        op = 1'b1;
        m = MODE_SYM;
      end else begin
        items[cnt[1:0]] = mk_item(KIND_NONE, 8'd0, 1'b0, 1'b0, 1'b0, 1'b1);
        cnt = cnt + 3'd1;
        m = MODE_HALT;
      end
    end

    // end of source flushes whatever is pending
    if (end_of_source) begin
      unique case (m)
        MODE_MINUS: begin
          items[cnt[1:0]] = mk_item(KIND_SYM, CH_MINUS, 1'b1, 1'b1, 1'b1, 1'b0);
          cnt = cnt + 3'd1;
        end
        MODE_INT, MODE_FRAC: begin
          items[cnt[1:0]] = mk_item(KIND_NUM, 8'd0, 1'b0, !op, 1'b1, 1'b0);
          cnt = cnt + 3'd1;
        end
        MODE_SYM: begin
          items[cnt[1:0]] = mk_item(KIND_SYM, 8'd0, 1'b0, !op, 1'b1, 1'b0);
          cnt = cnt + 3'd1;
        end
        MODE_STR: begin
          items[cnt[1:0]] = mk_item(KIND_STR, 8'd0, 1'b0, !op, 1'b1, 1'b0);
          cnt = cnt + 3'd1;
        end
        MODE_ESC: begin
          items[cnt[1:0]] = mk_item(KIND_STR, CH_BACKSLASH, 1'b1, !op, 1'b0, 1'b0);
          op = 1'b1;
          cnt = cnt + 3'd1;
          items[cnt[1:0]] = mk_item(KIND_STR, 8'd0, 1'b0, !op, 1'b1, 1'b0);
          cnt = cnt + 3'd1;
        end
        MODE_IDLE, MODE_HALT: begin
          cnt = cnt;
        end
        default: begin
          cnt = cnt;
        end
      endcase
      if (m != MODE_HALT) begin
        m = MODE_IDLE;
        op = 1'b0;
      end
    end

    mode_next = m;
    open_next = op;
    run.items = items;
    run.count = cnt;
  end

endmodule

[rtl/sxt_out_buf.sv]
module sxt_out_buf (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  sxt_pkg::run_t run,
  output logic          can_load,
  output logic          out_valid,
  input  logic          out_ready,
  output sxt_pkg::item_t item,
  output logic          run_end
);
  import sxt_pkg::*;

  item_t [RunDepth-1:0] items;
  logic  [2:0]          count;
  logic  [1:0]          idx;
  logic                 busy;
  logic                 at_end;
  logic                 last_taken;

  assign at_end     = ({1'b0, idx} == (count - 3'd1));
  assign last_taken = busy && out_ready && at_end;
  assign can_load   = !busy || last_taken;
  assign out_valid  = busy;
  assign item       = items[idx];
  assign run_end    = at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 2'd0;
    end else if (load) begin
      busy <= (run.count != 3'd0);
      idx  <= 2'd0;
    end else if (busy && out_ready) begin
      if (at_end) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      items <= run.items;
      count <= run.count;
    end
  end

endmodule
